### hw/rtl/dfwz_pkg.sv
package dfwz_pkg;

  localparam int unsigned ColW    = 12;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned ColorW  = 24;
  localparam int unsigned DepthW  = 16;
  localparam int unsigned DispW   = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned ViewW   = 5;
  localparam int unsigned LineW   = 13;
  localparam int unsigned WideW   = 14;
  localparam int unsigned Prod1W  = DispW + GainW + 1;
  localparam int unsigned Prod2W  = Prod1W + ViewW;
  localparam int unsigned FracW   = 16;
  localparam int unsigned TgtW    = Prod2W - FracW;
  localparam int unsigned EntryW  = DepthW + ColorW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW = 72;
  localparam int unsigned InUserW = 2;
  localparam int unsigned OutDataW = 40;

  localparam logic [CfgIdxW-1:0] CFG_VIEW_OFFSET = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SHIFT_GAIN  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LINE_WIDTH  = 2'd2;

  localparam logic OP_SCATTER = 1'b0;
  localparam logic OP_READ    = 1'b1;

  localparam logic signed [ViewW-1:0] VIEW_OFFSET_RST = 5'sd0;
  localparam logic [GainW-1:0]        SHIFT_GAIN_RST  = 16'd256;
  localparam logic [LineW-1:0]        LINE_WIDTH_RST  = 13'd4096;

  typedef struct packed {
    logic                   valid;
    logic signed [TgtW-1:0] target;
  } dfwz_tgt_t;

endpackage

### hw/rtl/dfwz_ram.sv
module dfwz_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/dfwz_shift.sv
module dfwz_shift (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [dfwz_pkg::DispW-1:0]    disparity_i,
  input  logic [dfwz_pkg::GainW-1:0]           gain_i,
  input  logic signed [dfwz_pkg::ViewW-1:0]    view_offset_i,
  input  logic [dfwz_pkg::ColW-1:0]            column_i,
  output dfwz_pkg::dfwz_tgt_t                  tgt_o
);
  import dfwz_pkg::*;

  logic                     v1_q, v2_q, v3_q, v4_q;
  logic signed [Prod1W-1:0] p1_q;
  logic signed [Prod2W-1:0] p2_q, bias;
  logic signed [TgtW-1:0]   sh_d, sh_q, tgt_q;
  logic [ColW-1:0]          col1_q, col2_q, col3_q;
  logic signed [ViewW-1:0]  vo1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Negative products are biased before the arithmetic shift so that the
  // quotient truncates toward zero.
  assign bias = p2_q[Prod2W-1] ? Prod2W'((1 << FracW) - 1) : '0;
  assign sh_d = TgtW'((p2_q + bias) >>> FracW);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p1_q   <= Prod1W'(disparity_i * $signed({1'b0, gain_i}));
      vo1_q  <= view_offset_i;
      col1_q <= column_i;
    end
    p2_q   <= Prod2W'(p1_q * vo1_q);
    col2_q <= col1_q;
    sh_q   <= sh_d;
    col3_q <= col2_q;
    tgt_q  <= sh_q + $signed(TgtW'(col3_q));
  end

  assign tgt_o.valid  = v4_q;
  assign tgt_o.target = tgt_q;

endmodule

### hw/rtl/disparity_forward_warp_zbuffer.sv
// Channel   Direction  Beat contents
// s_axis    in         tuser: opcode, depth_invalid; tdata: column, red, green, blue,
//                      shift_disparity, depth_disparity
// m_axis    out        tuser: hole; tdata: out_column, out_red, out_green, out_blue
// cfg       in         cfg_we_i, cfg_idx_i, cfg_wdata_i; one register per write
//
// A scatter beat is accepted, passes through the multiply and shift pipeline, whose last
// step reads the line memory, and then has a step to write it back. A scatter whose
// target falls off the line ends without the read and the write-back. After reset a
// clearing pass sweeps the line memory before the first beat is taken. A pending result
// stalls only the next beat.
module disparity_forward_warp_zbuffer #(
  parameter int unsigned LINE_MAX = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // column[11:0], red[19:12], green[27:20], blue[35:28], shift_disparity[51:36],
  // depth_disparity[67:52], zero fill[71:68]
  input  logic [dfwz_pkg::InDataW-1:0]    s_axis_tdata_i,
  // opcode[0], depth_invalid[1]
  input  logic [dfwz_pkg::InUserW-1:0]    s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // out_column[11:0], out_red[19:12], out_green[27:20], out_blue[35:28], zero fill[39:36]
  output logic [dfwz_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // hole[0]
  output logic                            m_axis_tuser_o,
  input  logic                            cfg_we_i,
  input  logic [dfwz_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dfwz_pkg::CfgW-1:0]       cfg_wdata_i
);
  import dfwz_pkg::*;

  localparam int unsigned AW = $clog2(LINE_MAX);
  localparam logic [WideW-1:0] LineMaxW = WideW'(LINE_MAX);
  localparam logic [AW-1:0]    LastAddr = AW'(LINE_MAX - 1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_WARP   = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_READ   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic signed [ViewW-1:0] view_offset_q;
  logic [GainW-1:0]        shift_gain_q;
  logic [LineW-1:0]        line_width_q;

  logic [AW-1:0]     clr_q, clr_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic              in_range_q, in_range_d;
  logic [ColW-1:0]   col_q;
  logic [ColorW-1:0] color_q;
  logic [DepthW-1:0] dd_q;

  logic              out_vld_q, out_vld_d;
  logic [ColW-1:0]   out_col_q, out_col_d;
  logic [ColorW-1:0] out_color_q, out_color_d;
  logic              out_hole_q, out_hole_d;

  logic              accept, load_item;
  logic [ColW-1:0]   in_col;
  logic [ColorW-1:0] in_color;
  logic [DispW-1:0]  in_sd;
  logic [DepthW-1:0] in_dd;
  logic              in_op, in_inval;
  logic [WideW-1:0]  in_col_w, width_eff;
  logic              tgt_ok;
  dfwz_tgt_t         tgt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  logic [DepthW-1:0] old_depth;

  assign in_col   = s_axis_tdata_i[11:0];
  assign in_color = {s_axis_tdata_i[19:12], s_axis_tdata_i[27:20], s_axis_tdata_i[35:28]};
  assign in_sd    = s_axis_tdata_i[51:36];
  assign in_dd    = s_axis_tdata_i[67:52];
  assign in_op    = s_axis_tuser_i[0];
  assign in_inval = s_axis_tuser_i[1];
  assign in_col_w = WideW'(in_col);

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_vld_q || m_axis_tready_i);
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign load_item = accept && (in_op == OP_SCATTER) && !in_inval;

  assign width_eff = (WideW'(line_width_q) > LineMaxW) ? LineMaxW : WideW'(line_width_q);
  assign tgt_ok    = !tgt.target[TgtW-1] && (tgt.target < $signed(TgtW'(width_eff)));
  assign old_depth = ram_rdata[EntryW-1:ColorW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_offset_q <= VIEW_OFFSET_RST;
      shift_gain_q  <= SHIFT_GAIN_RST;
      line_width_q  <= LINE_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VIEW_OFFSET: view_offset_q <= $signed(cfg_wdata_i[ViewW-1:0]);
        CFG_SHIFT_GAIN:  shift_gain_q  <= cfg_wdata_i[GainW-1:0];
        CFG_LINE_WIDTH:  line_width_q  <= cfg_wdata_i[LineW-1:0];
        default: ;
      endcase
    end
  end

  dfwz_shift u_shift (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (load_item),
    .disparity_i   ($signed(in_sd)),
    .gain_i        (shift_gain_q),
    .view_offset_i (view_offset_q),
    .column_i      (in_col),
    .tgt_o         (tgt)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    addr_d      = addr_q;
    in_range_d  = in_range_q;
    out_vld_d   = out_vld_q && !m_axis_tready_i;
    out_col_d   = out_col_q;
    out_color_d = out_color_q;
    out_hole_d  = out_hole_q;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = in_col_w[AW-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_READ) begin
            ram_re     = 1'b1;
            addr_d     = in_col_w[AW-1:0];
            in_range_d = in_col_w < LineMaxW;
            state_d    = ST_READ;
          end else if (!in_inval) begin
            state_d = ST_WARP;
          end
        end
      end
      ST_WARP: begin
        ram_raddr = tgt.target[AW-1:0];
        if (tgt.valid) begin
          if (tgt_ok) begin
            ram_re  = 1'b1;
            addr_d  = tgt.target[AW-1:0];
            state_d = ST_UPDATE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_UPDATE: begin
        if (dd_q > old_depth) begin
          ram_we    = 1'b1;
          ram_wdata = {dd_q, color_q};
        end
        state_d = ST_IDLE;
      end
      ST_READ: begin
        out_vld_d = 1'b1;
        out_col_d = col_q;
        if (in_range_q) begin
          ram_we      = 1'b1;
          out_color_d = ram_rdata[ColorW-1:0];
          out_hole_d  = (old_depth == '0);
        end else begin
          out_color_d = '0;
          out_hole_d  = 1'b1;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    in_range_q  <= in_range_d;
    out_col_q   <= out_col_d;
    out_color_q <= out_color_d;
    out_hole_q  <= out_hole_d;
    if (accept) begin
      col_q   <= in_col;
      color_q <= in_color;
      dd_q    <= in_dd;
    end
  end

  dfwz_ram #(
    .WIDTH (EntryW),
    .DEPTH (LINE_MAX)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0, out_color_q[7:0], out_color_q[15:8], out_color_q[23:16],
                            out_col_q};
  assign m_axis_tuser_o  = out_hole_q;

`ifndef ASSERT_OFF
  a_no_beat_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready_o)
    else $error("Input beat taken during the clearing pass.");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_READ))
    else $error("Result raised without a read.");

  a_depth_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q == ST_UPDATE)) |-> (dd_q > old_depth))
    else $error("Scatter overwrote a nearer pixel.");
`endif

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dfwz_pkg::*;

  localparam int unsigned LINE_CAP = 4096;
  localparam int unsigned PHASE_BEATS = 180;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic                    opcode;
    logic [ColW-1:0]         column;
    logic [ChanW-1:0]        red;
    logic [ChanW-1:0]        green;
    logic [ChanW-1:0]        blue;
    logic signed [DispW-1:0] shift_disp;
    logic [DepthW-1:0]       depth_disp;
    logic                    depth_inval;
  } warp_beat_t;

  typedef struct {
    logic [ColW-1:0]  column;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             hole;
  } column_read_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [InUserW-1:0]  s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgW-1:0]     cfg_wdata = '0;

  warp_beat_t   pending_beats[$];
  column_read_t read_expect[$];
  warp_beat_t   drv_beat;
  column_read_t seen_read;

  logic [ColorW-1:0] line_color[LINE_CAP];
  logic [DepthW-1:0] line_depth[LINE_CAP];
  logic              line_hole[LINE_CAP];

  int view_offset = 0;
  int shift_gain = 256;
  int line_width = 4096;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fails = 0;

  disparity_forward_warp_zbuffer #(
    .LINE_MAX(LINE_CAP)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint warp_shift(input logic signed [DispW-1:0] disp);
    longint prod;
    longint mag;
    prod = longint'(disp) * longint'(shift_gain) * longint'(view_offset);
    mag = prod < 0 ? -prod : prod;
    mag = mag >> 16;
    return prod < 0 ? -mag : mag;
  endfunction

  task automatic warp_apply(input warp_beat_t b);
    column_read_t r;
    longint       target;
    longint       lim;
    int           t;
    if (b.opcode == OP_READ) begin
      r.column = b.column;
      {r.red, r.green, r.blue} = line_color[b.column];
      r.hole = line_hole[b.column];
      read_expect.push_back(r);
      line_color[b.column] = '0;
      line_depth[b.column] = '0;
      line_hole[b.column] = 1'b1;
    end else if (!b.depth_inval) begin
      lim = line_width > LINE_CAP ? LINE_CAP : line_width;
      target = longint'(b.column) + warp_shift(b.shift_disp);
      if (target >= 0 && target < lim) begin
        t = int'(target);
        if (b.depth_disp > line_depth[t]) begin
          line_color[t] = {b.red, b.green, b.blue};
          line_depth[t] = b.depth_disp;
          line_hole[t] = 1'b0;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        warp_apply(drv_beat);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_beat = pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'b0, drv_beat.depth_disp, drv_beat.shift_disp, drv_beat.blue,
                           drv_beat.green, drv_beat.red, drv_beat.column};
          s_axis_tuser <= {drv_beat.depth_inval, drv_beat.opcode};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (read_expect.size() == 0) begin
          $error("result beat for column 0x%0h with no read pending", m_axis_tdata[11:0]);
          fails++;
        end else begin
          seen_read = read_expect.pop_front();
          check_field("out_column", 16'(seen_read.column), 16'(m_axis_tdata[11:0]));
          check_field("out_red", 16'(seen_read.red), 16'(m_axis_tdata[19:12]));
          check_field("out_green", 16'(seen_read.green), 16'(m_axis_tdata[27:20]));
          check_field("out_blue", 16'(seen_read.blue), 16'(m_axis_tdata[35:28]));
          check_field("hole", 16'(seen_read.hole), 16'(m_axis_tuser));
        end
      end
      m_axis_tready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  task automatic push_beat(input logic op, input logic [ColW-1:0] col,
                           input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                           input logic [ChanW-1:0] b, input logic [DispW-1:0] sd,
                           input logic [DepthW-1:0] dd, input logic inv);
    warp_beat_t w;
    w.opcode = op;
    w.column = col;
    w.red = r;
    w.green = g;
    w.blue = b;
    w.shift_disp = sd;
    w.depth_disp = dd;
    w.depth_inval = inv;
    pending_beats.push_back(w);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_VIEW_OFFSET: view_offset = int'($signed(val[ViewW-1:0]));
      CFG_SHIFT_GAIN:  shift_gain = int'(val);
      CFG_LINE_WIDTH:  line_width = int'(val[LineW-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_view(input int vo, input int gain, input int width);
    logic [CfgW-1:0] junk;
    junk = CfgW'($urandom);
    write_reg(CFG_VIEW_OFFSET, {junk[CfgW-1:ViewW], ViewW'(vo)});
    write_reg(CFG_SHIFT_GAIN, CfgW'(gain));
    write_reg(CFG_LINE_WIDTH, {junk[CfgW-1:LineW], LineW'(width)});
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 19;
        recv_stall_pct = 78;
      end
      1: begin
        send_idle_pct = 78;
        recv_stall_pct = 19;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || s_axis_tvalid || read_expect.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Bursts scatter into a narrow window with shifts of a few columns, so that
  // pixels collide and the depth test decides, then read the window back.
  task automatic random_phase(input int vo, input int gain, input int width, input int mode);
    int                      made;
    int                      eff;
    int                      scale;
    int                      rng;
    int                      base;
    logic                    op;
    logic                    inv;
    logic signed [DispW-1:0] sd;
    logic [DepthW-1:0]       dd;
    set_view(vo, gain, width);
    set_idle(mode);
    made = 0;
    eff = line_width > LINE_CAP ? LINE_CAP : line_width;
    scale = shift_gain * (view_offset < 0 ? -view_offset : view_offset);
    rng = scale == 0 ? 32767 : 262144 / scale;
    if (rng > 32767) rng = 32767;
    if (rng < 1) rng = 1;
    while (made < PHASE_BEATS) begin
      if ($urandom_range(0, 9) < 7) begin
        base = eff > 0 ? $urandom_range(0, eff - 1) : $urandom_range(0, LINE_CAP - 1);
        repeat ($urandom_range(2, 12)) begin
          sd = DispW'($urandom_range(0, 2 * rng) - rng);
          dd = $urandom_range(0, 3) == 0 ? DepthW'($urandom) : DepthW'($urandom_range(0, 15));
          inv = $urandom_range(0, 7) == 0;
          push_beat(OP_SCATTER, ColW'(base + $urandom_range(0, 7)), ChanW'($urandom),
                    ChanW'($urandom), ChanW'($urandom), sd, dd, inv);
          if (!inv) made++;
        end
        for (int c = base - 8; c < base + 16; c++) begin
          if (c >= 0 && c < LINE_CAP) begin
            push_beat(OP_READ, ColW'(c), ChanW'($urandom), ChanW'($urandom),
                      ChanW'($urandom), DispW'($urandom), DepthW'($urandom), 1'($urandom));
            made++;
          end
        end
      end else begin
        op = 1'($urandom);
        inv = 1'($urandom);
        push_beat(op, ColW'($urandom), ChanW'($urandom), ChanW'($urandom), ChanW'($urandom),
                  DispW'($urandom), DepthW'($urandom), inv);
        if (op == OP_READ || !inv) made++;
      end
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < LINE_CAP; i++) begin
      line_color[i] = '0;
      line_depth[i] = '0;
      line_hole[i] = 1'b1;
    end
    set_idle(0);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers at their reset values: no shift at all.
    push_beat(OP_SCATTER, 12'd4095, 8'hFF, 8'hFF, 8'hFF, DispW'(-32768), 16'hFFFF, 1'b0);
    push_beat(OP_READ, 12'd4095, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0);
    push_beat(OP_SCATTER, 12'd7, 8'h12, 8'h34, 8'h56, 16'h0000, 16'h0000, 1'b0);
    push_beat(OP_READ, 12'd7, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_beat(OP_SCATTER, 12'd3000, 8'hA5, 8'h5A, 8'hC3, 16'h7FFF, 16'd9, 1'b0);
    drain();

    set_view(1, 256, 100);
    write_reg(CFG_SPARE, 16'hFFFF);
    push_beat(OP_SCATTER, 12'd10, 8'h11, 8'h22, 8'h33, DispW'(1280), 16'd50, 1'b0);
    push_beat(OP_SCATTER, 12'd20, 8'h44, 8'h55, 8'h66, DispW'(-1280), 16'd50, 1'b0);
    push_beat(OP_SCATTER, 12'd12, 8'h77, 8'h88, 8'h99, DispW'(768), 16'd51, 1'b0);
    push_beat(OP_SCATTER, 12'd15, 8'h01, 8'h02, 8'h03, 16'h0000, 16'd60000, 1'b1);
    push_beat(OP_READ, 12'd15, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0);
    push_beat(OP_READ, 12'd15, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0);
    push_beat(OP_SCATTER, 12'd3, 8'hDE, 8'hAD, 8'hBE, DispW'(-1024), 16'd10, 1'b0);
    push_beat(OP_SCATTER, 12'd99, 8'hDE, 8'hAD, 8'hBE, DispW'(256), 16'd10, 1'b0);
    push_beat(OP_SCATTER, 12'd200, 8'hCA, 8'hFE, 8'h01, DispW'(-25856), 16'd3, 1'b0);
    push_beat(OP_READ, 12'd99, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0);
    push_beat(OP_READ, 12'd3000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0);
    push_beat(OP_SCATTER, 12'd40, 8'h0F, 8'hF0, 8'h3C, DispW'(-385), 16'd7, 1'b0);
    push_beat(OP_READ, 12'd39, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0);
    drain();

    random_phase(1, 256, 4096, 0);
    random_phase(-16, 65535, 4096, 0);
    random_phase(15, 0, 8191, 0);
    random_phase(-3, 300, 1, 1);
    random_phase(2, 128, 0, 1);
    random_phase(-1, 1000, 640, 2);
    random_phase(7, 40000, 4096, 2);

    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### disparity_forward_warp_zbuffer.f
hw/rtl/dfwz_pkg.sv
hw/rtl/dfwz_ram.sv
hw/rtl/dfwz_shift.sv
hw/rtl/disparity_forward_warp_zbuffer.sv
tb/tb.sv
